/* rtl/flash_block_allocator_with_aging_macros.svh */
// Assertion macros for the flash block allocator checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FLASH_BLOCK_ALLOCATOR_WITH_AGING_MACROS_SVH
`define FLASH_BLOCK_ALLOCATOR_WITH_AGING_MACROS_SVH

// Same-cycle implication, skipped while reset is asserted.
`define FBAA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbaa check failed");

// Next-cycle implication, skipped while reset is asserted.
`define FBAA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbaa check failed");

`endif

/* rtl/fbaa_pkg.sv */
// Shared types, constants and helpers for the flash block allocator.
// No dependencies; used by every module of the block.
package fbaa_pkg;

  localparam int FUNC_W  = 2;
  localparam int TYPE_W  = 4;
  localparam int BLK_W   = 10;
  localparam int ENTRY_W = 8;
  localparam int USED_W  = 11;
  localparam int AGE_W   = 4;

  localparam int DEF_BLOCK_COUNT     = 1024;
  localparam int DEF_PROTECTED_COUNT = 2;
  localparam int QUEUE_DEPTH         = 2;

  // Count saturates at the largest value the used counter can show.
  localparam int USED_MAX    = (1 << USED_W) - 1;
  // Free space is measured in sixteenths of the table.
  localparam int AVAIL_SLOTS = 16;

  localparam logic [AGE_W-1:0] AGE_IMMORTAL = 4'hF;
  localparam logic [AGE_W-1:0] AGE_BIRTH    = 4'b1100;
  localparam logic [AGE_W-1:0] AGE_NONE     = 4'h0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_ROOT  = 2'd2,
    FUNC_LOAD  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_ROOT,
    OP_LOAD,
    OP_REFUSE,
    OP_SKIP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [TYPE_W-1:0]  ftype;
    logic [BLK_W-1:0]   blk_id;
    logic [ENTRY_W-1:0] entry_value;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_ALLOC_WR,
    ST_CHECK,
    ST_RMW,
    ST_DONE
  } state_t;

  // Age one entry: ages 1..14 drop by one, free and immortal ages hold.
  function automatic logic [ENTRY_W-1:0] age_entry(input logic [ENTRY_W-1:0] e);
    logic [ENTRY_W-1:0] r;
    r = e;
    if ((e[AGE_W-1:0] != AGE_NONE) && (e[AGE_W-1:0] != AGE_IMMORTAL)) begin
      r = e - ENTRY_W'(1);
    end
    return r;
  endfunction

endpackage

/* rtl/fbaa_front.sv */
// Front end of the allocator: input handshake and command classification.
// Depends on fbaa_pkg.
module fbaa_front #(
  parameter int BLOCK_COUNT     = fbaa_pkg::DEF_BLOCK_COUNT,
  parameter int PROTECTED_COUNT = fbaa_pkg::DEF_PROTECTED_COUNT
) (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fbaa_pkg::FUNC_W-1:0]  in_func,
  input  logic [fbaa_pkg::TYPE_W-1:0]  in_ftype,
  input  logic [fbaa_pkg::BLK_W-1:0]   in_blk_id,
  input  logic [fbaa_pkg::ENTRY_W-1:0] in_entry_value,
  input  logic                         clr_done,
  input  logic                         q_full,
  output logic                         q_push,
  output fbaa_pkg::cmd_t               q_cmd
);

  logic in_range;
  logic is_prot;

  assign in_range = 32'(in_blk_id) < BLOCK_COUNT;
  assign is_prot  = 32'(in_blk_id) < PROTECTED_COUNT;

  // Hold off while the table is being cleared or the queue is full.
  assign in_ready = clr_done && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_cmd.ftype       = in_ftype;
    q_cmd.blk_id      = in_blk_id;
    q_cmd.entry_value = in_entry_value;
    unique case (fbaa_pkg::func_t'(in_func))
      fbaa_pkg::FUNC_ALLOC: q_cmd.op = fbaa_pkg::OP_ALLOC;
      fbaa_pkg::FUNC_FREE: begin
        if (!in_range)    q_cmd.op = fbaa_pkg::OP_SKIP;
        else if (is_prot) q_cmd.op = fbaa_pkg::OP_REFUSE;
        else              q_cmd.op = fbaa_pkg::OP_FREE;
      end
      fbaa_pkg::FUNC_ROOT: q_cmd.op = in_range ? fbaa_pkg::OP_ROOT : fbaa_pkg::OP_SKIP;
      fbaa_pkg::FUNC_LOAD: q_cmd.op = in_range ? fbaa_pkg::OP_LOAD : fbaa_pkg::OP_SKIP;
      default:             q_cmd.op = fbaa_pkg::OP_SKIP;
    endcase
  end

endmodule

/* rtl/fbaa_queue.sv */
// Short command queue between the allocator front end and back end.
// Depends on fbaa_pkg.
module fbaa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fbaa_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output fbaa_pkg::cmd_t head_cmd
);

  localparam int PW = (fbaa_pkg::QUEUE_DEPTH > 1) ? $clog2(fbaa_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(fbaa_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(fbaa_pkg::QUEUE_DEPTH - 1);

  fbaa_pkg::cmd_t slot_r [fbaa_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = count_r == CW'(fbaa_pkg::QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign head_cmd = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/fbaa_back.sv */
// Back end of the allocator: entry table memory, scan/ageing sequencer, result register.
// Depends on fbaa_pkg.
module fbaa_back #(
  parameter int BLOCK_COUNT     = fbaa_pkg::DEF_BLOCK_COUNT,
  parameter int PROTECTED_COUNT = fbaa_pkg::DEF_PROTECTED_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  fbaa_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         clr_done,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fbaa_pkg::BLK_W-1:0]   out_result_block,
  output logic                         out_status,
  output logic                         out_reallocated,
  output logic [fbaa_pkg::ENTRY_W-1:0] out_previous_entry,
  output logic [fbaa_pkg::USED_W-1:0]  out_used_count
);

  localparam int IDX_W    = $clog2(BLOCK_COUNT);
  localparam int CNT_W    = $clog2(BLOCK_COUNT + 1);
  localparam int BW       = fbaa_pkg::BLK_W;
  localparam int EW       = fbaa_pkg::ENTRY_W;
  localparam int UW       = fbaa_pkg::USED_W;
  localparam int AW       = fbaa_pkg::AGE_W;
  localparam int TH_W     = $clog2((fbaa_pkg::AVAIL_SLOTS + 1) * BLOCK_COUNT + 1);
  localparam int USED_CAP = (BLOCK_COUNT < fbaa_pkg::USED_MAX) ? BLOCK_COUNT
                                                              : fbaa_pkg::USED_MAX;
  localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(BLOCK_COUNT);
  localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(PROTECTED_COUNT);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(PROTECTED_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BLOCK_COUNT - 1);

  // Entry table
  logic [EW-1:0]    mem_r [BLOCK_COUNT];
  logic [EW-1:0]    rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [EW-1:0]    mem_wd;

  fbaa_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  fbaa_pkg::cmd_t   cmd_r, cmd_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] old_id_r, old_id_nxt;
  logic [EW-1:0]    old_entry_r, old_entry_nxt;
  logic [AW-1:0]    old_age_r, old_age_nxt;
  logic             age_ret_r, age_ret_nxt;
  logic [BW-1:0]    res_block_r, res_block_nxt;
  logic             status_r, status_nxt;
  logic             realloc_r, realloc_nxt;
  logic [EW-1:0]    prev_r, prev_nxt;
  logic [UW-1:0]    used_r, used_nxt;
  logic [EW-1:0]    entry0_r, entry0_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [BW-1:0]    out_block_r, out_block_nxt;
  logic             out_status_r, out_status_nxt;
  logic             out_realloc_r, out_realloc_nxt;
  logic [EW-1:0]    out_prev_r, out_prev_nxt;
  logic [UW-1:0]    out_used_r, out_used_nxt;

  logic [AW-1:0]    rd_age;
  logic [AW-1:0]    anchor;
  logic [TH_W-1:0]  age_thr;
  logic             age_due;

  assign rd_age = rd_data_r[AW-1:0];
  assign anchor = entry0_r[AW-1:0];

  // Free space in sixteenths falls below the anchor age exactly when
  // 16 * used reaches (17 - anchor) * BLOCK_COUNT.
  assign age_thr = TH_W'(32'(5'(fbaa_pkg::AVAIL_SLOTS + 1) - {1'b0, anchor})
                         * 32'(BLOCK_COUNT));
  assign age_due = (anchor != fbaa_pkg::AGE_NONE)
                && (32'({used_r, 4'b0000}) >= 32'(age_thr));

  assign clr_done           = state_r != fbaa_pkg::ST_CLEAR;
  assign out_valid          = out_valid_r;
  assign out_result_block   = out_block_r;
  assign out_status         = out_status_r;
  assign out_reallocated    = out_realloc_r;
  assign out_previous_entry = out_prev_r;
  assign out_used_count     = out_used_r;

  always_comb begin
    logic upd;
    upd             = 1'b0;
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    pend_nxt        = 1'b0;
    pidx_nxt        = pidx_r;
    cmd_nxt         = cmd_r;
    found_nxt       = found_r;
    old_id_nxt      = old_id_r;
    old_entry_nxt   = old_entry_r;
    old_age_nxt     = old_age_r;
    age_ret_nxt     = age_ret_r;
    res_block_nxt   = res_block_r;
    status_nxt      = status_r;
    realloc_nxt     = realloc_r;
    prev_nxt        = prev_r;
    used_nxt        = used_r;
    entry0_nxt      = entry0_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_block_nxt   = out_block_r;
    out_status_nxt  = out_status_r;
    out_realloc_nxt = out_realloc_r;
    out_prev_nxt    = out_prev_r;
    out_used_nxt    = out_used_r;
    rd_addr         = idx_r[IDX_W-1:0];
    mem_we          = 1'b0;
    mem_wa          = '0;
    mem_wd          = '0;
    q_pop           = 1'b0;

    unique case (state_r)
      fbaa_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx_r[IDX_W-1:0];
        if (idx_r[IDX_W-1:0] == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = fbaa_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      fbaa_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          cmd_nxt       = q_cmd;
          res_block_nxt = q_cmd.blk_id;
          status_nxt    = 1'b0;
          realloc_nxt   = 1'b0;
          prev_nxt      = '0;
          unique case (q_cmd.op)
            fbaa_pkg::OP_ALLOC: begin
              idx_nxt   = CNT_FIRST;
              found_nxt = 1'b0;
              state_nxt = fbaa_pkg::ST_SCAN;
            end
            fbaa_pkg::OP_FREE, fbaa_pkg::OP_ROOT, fbaa_pkg::OP_LOAD,
            fbaa_pkg::OP_REFUSE: begin
              rd_addr   = IDX_W'(q_cmd.blk_id);
              state_nxt = fbaa_pkg::ST_RMW;
            end
            fbaa_pkg::OP_SKIP: state_nxt = fbaa_pkg::ST_DONE;
            default:           state_nxt = fbaa_pkg::ST_DONE;
          endcase
        end
      end

      fbaa_pkg::ST_SCAN: begin
        if (idx_r < CNT_END) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end
        if (pend_r) begin
          // First free entry wins; else keep the first entry of least age.
          upd = (pidx_r == FIRST_IDX) || (rd_data_r == '0) || (rd_age < old_age_r);
          if (upd) begin
            old_id_nxt    = pidx_r;
            old_entry_nxt = rd_data_r;
            old_age_nxt   = rd_age;
            found_nxt     = rd_data_r == '0;
          end
          if (rd_data_r == '0) begin
            state_nxt = fbaa_pkg::ST_ALLOC_WR;
          end else if (pidx_r == LAST_IDX) begin
            if (old_age_nxt != fbaa_pkg::AGE_NONE) begin
              idx_nxt     = '0;
              pend_nxt    = 1'b0;
              age_ret_nxt = 1'b1;
              state_nxt   = fbaa_pkg::ST_AGE;
            end else begin
              state_nxt = fbaa_pkg::ST_ALLOC_WR;
            end
          end
        end
      end

      fbaa_pkg::ST_AGE: begin
        if (idx_r < CNT_END) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end
        // Write back one entry behind the read pointer.
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = pidx_r;
          mem_wd = fbaa_pkg::age_entry(rd_data_r);
          if (pidx_r == LAST_IDX) begin
            age_ret_nxt = 1'b0;
            state_nxt   = age_ret_r ? fbaa_pkg::ST_ALLOC_WR : fbaa_pkg::ST_DONE;
          end
        end
      end

      fbaa_pkg::ST_ALLOC_WR: begin
        mem_we        = 1'b1;
        mem_wa        = old_id_r;
        mem_wd        = {cmd_r.ftype, fbaa_pkg::AGE_BIRTH};
        res_block_nxt = BW'(old_id_r);
        prev_nxt      = old_entry_r;
        realloc_nxt   = !found_r;
        if (found_r && (32'(used_r) < USED_CAP)) begin
          used_nxt = used_r + UW'(1);
        end
        state_nxt = fbaa_pkg::ST_CHECK;
      end

      fbaa_pkg::ST_CHECK: begin
        if (age_due) begin
          idx_nxt     = '0;
          age_ret_nxt = 1'b0;
          state_nxt   = fbaa_pkg::ST_AGE;
        end else begin
          state_nxt = fbaa_pkg::ST_DONE;
        end
      end

      fbaa_pkg::ST_RMW: begin
        prev_nxt = rd_data_r;
        mem_wa   = IDX_W'(cmd_r.blk_id);
        unique case (cmd_r.op)
          fbaa_pkg::OP_FREE: begin
            mem_we = 1'b1;
            if (used_r != '0) begin
              used_nxt = used_r - UW'(1);
            end
          end
          fbaa_pkg::OP_ROOT: begin
            mem_we = 1'b1;
            mem_wd = {rd_data_r[EW-1:AW], fbaa_pkg::AGE_IMMORTAL};
          end
          fbaa_pkg::OP_LOAD: begin
            mem_we = 1'b1;
            mem_wd = cmd_r.entry_value;
          end
          fbaa_pkg::OP_REFUSE: status_nxt = 1'b1;
          default:             status_nxt = 1'b0;
        endcase
        state_nxt = fbaa_pkg::ST_DONE;
      end

      fbaa_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_block_nxt   = res_block_r;
          out_status_nxt  = status_r;
          out_realloc_nxt = realloc_r;
          out_prev_nxt    = prev_r;
          out_used_nxt    = used_r;
          state_nxt       = fbaa_pkg::ST_IDLE;
        end
      end

      default: state_nxt = fbaa_pkg::ST_IDLE;
    endcase

    // Shadow copy of block 0 supplies the ageing anchor without a read.
    if (mem_we && (mem_wa == '0)) begin
      entry0_nxt = mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbaa_pkg::ST_CLEAR;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      age_ret_r   <= 1'b0;
      used_r      <= '0;
      entry0_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      age_ret_r   <= age_ret_nxt;
      used_r      <= used_nxt;
      entry0_r    <= entry0_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r        <= pidx_nxt;
    cmd_r         <= cmd_nxt;
    old_id_r      <= old_id_nxt;
    old_entry_r   <= old_entry_nxt;
    old_age_r     <= old_age_nxt;
    res_block_r   <= res_block_nxt;
    status_r      <= status_nxt;
    realloc_r     <= realloc_nxt;
    prev_r        <= prev_nxt;
    out_block_r   <= out_block_nxt;
    out_status_r  <= out_status_nxt;
    out_realloc_r <= out_realloc_nxt;
    out_prev_r    <= out_prev_nxt;
    out_used_r    <= out_used_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

/* rtl/flash_block_allocator_with_aging.sv */
// Top level of the flash block allocator: front end, command queue, back end (fbaa_pkg).
// Free, root and load do one read-modify-write of the entry; allocate scans the blocks from
// the first unprotected one and may add a full ageing pass before and after its write (at
// most two). The back end works on one request at a time; the queue takes new requests
// meanwhile until it is full. Reset: a clearing sweep zeroes the table; in_ready stays low.
module flash_block_allocator_with_aging #(
  parameter int BLOCK_COUNT     = fbaa_pkg::DEF_BLOCK_COUNT,
  parameter int PROTECTED_COUNT = fbaa_pkg::DEF_PROTECTED_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fbaa_pkg::FUNC_W-1:0]  in_func,
  input  logic [fbaa_pkg::TYPE_W-1:0]  in_ftype,
  input  logic [fbaa_pkg::BLK_W-1:0]   in_blk_id,
  input  logic [fbaa_pkg::ENTRY_W-1:0] in_entry_value,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fbaa_pkg::BLK_W-1:0]   out_result_block,
  output logic                         out_status,
  output logic                         out_reallocated,
  output logic [fbaa_pkg::ENTRY_W-1:0] out_previous_entry,
  output logic [fbaa_pkg::USED_W-1:0]  out_used_count
);

  // Front end to queue
  logic           q_push;
  logic           q_full;
  fbaa_pkg::cmd_t q_push_cmd;

  // Queue to back end
  logic           q_pop;
  logic           q_empty;
  fbaa_pkg::cmd_t q_head_cmd;

  // High once the clearing sweep has finished
  logic           clr_done;

  // Decode the request and sort out-of-range and protected cases up front,
  // so the back end only sees work it must carry out.
  fbaa_front #(
    .BLOCK_COUNT     (BLOCK_COUNT),
    .PROTECTED_COUNT (PROTECTED_COUNT)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_ftype       (in_ftype),
    .in_blk_id      (in_blk_id),
    .in_entry_value (in_entry_value),
    .clr_done       (clr_done),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_push_cmd)
  );

  // Decouple the request transfer from the long table passes.
  fbaa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (q_head_cmd)
  );

  // Scan, age and update the entry table; hold the result until transferred.
  fbaa_back #(
    .BLOCK_COUNT     (BLOCK_COUNT),
    .PROTECTED_COUNT (PROTECTED_COUNT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (!q_empty),
    .q_cmd              (q_head_cmd),
    .q_pop              (q_pop),
    .clr_done           (clr_done),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_block   (out_result_block),
    .out_status         (out_status),
    .out_reallocated    (out_reallocated),
    .out_previous_entry (out_previous_entry),
    .out_used_count     (out_used_count)
  );

endmodule

/* rtl/fbaa_checker.sv */
// Port-level checker for the flash block allocator, bound to the top level.
// Depends on fbaa_pkg and flash_block_allocator_with_aging_macros.svh.
`include "flash_block_allocator_with_aging_macros.svh"

module fbaa_checker #(
  parameter int BLOCK_COUNT     = fbaa_pkg::DEF_BLOCK_COUNT,
  parameter int PROTECTED_COUNT = fbaa_pkg::DEF_PROTECTED_COUNT
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [fbaa_pkg::BLK_W-1:0]   out_result_block,
  input logic                         out_status,
  input logic                         out_reallocated,
  input logic [fbaa_pkg::ENTRY_W-1:0] out_previous_entry,
  input logic [fbaa_pkg::USED_W-1:0]  out_used_count
);

  // A refusal only comes from freeing a protected block, never from an allocation.
  `FBAA_ASSERT_IMPLY(a_refuse_prot, out_valid && out_status, !out_reallocated && (32'(out_result_block) < PROTECTED_COUNT))

  // Eviction only happens when the chosen block was in use.
  `FBAA_ASSERT_IMPLY(a_evict_used, out_valid && out_reallocated, out_previous_entry != 8'h00)

  // The used count never exceeds the table size.
  `FBAA_ASSERT_IMPLY(a_used_bound, out_valid, 32'(out_used_count) <= BLOCK_COUNT)

  // A stalled result holds.
  `FBAA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result_block) && $stable(out_used_count))

endmodule

bind flash_block_allocator_with_aging fbaa_checker #(
  .BLOCK_COUNT     (BLOCK_COUNT),
  .PROTECTED_COUNT (PROTECTED_COUNT)
) u_fbaa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_block   (out_result_block),
  .out_status         (out_status),
  .out_reallocated    (out_reallocated),
  .out_previous_entry (out_previous_entry),
  .out_used_count     (out_used_count)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for flash_block_allocator_with_aging: a block-table tracker class
// predicts every reply, plain tasks drive requests and an initial block takes replies with random pacing.
// Depends on fbaa_pkg and the allocator RTL only.

import fbaa_pkg::*;

localparam int BLOCKS   = DEF_BLOCK_COUNT;
localparam int GUARDED  = DEF_PROTECTED_COUNT;
localparam int USED_CAP = (BLOCKS < 2047) ? BLOCKS : 2047;

typedef struct packed {
  logic [BLK_W-1:0]   blk;
  logic               refused;
  logic               evicted;
  logic [ENTRY_W-1:0] prior;
  logic [USED_W-1:0]  used;
} reply_t;

class block_table_tracker;
  bit [ENTRY_W-1:0] tbl [BLOCKS];
  int               used;
  int               peak_used;
  reply_t           due [$];
  int               tally [4];
  int               evictions;
  int               refusals;
  int               checked;
  int               errors;

  function void age_table();
    for (int i = 0; i < BLOCKS; i++) begin
      if (tbl[i][AGE_W-1:0] != AGE_NONE && tbl[i][AGE_W-1:0] != AGE_IMMORTAL) begin
        tbl[i] = tbl[i] - ENTRY_W'(1);
      end
    end
  endfunction

  function void take_request(func_t f, logic [TYPE_W-1:0] ft, logic [BLK_W-1:0] b,
                             logic [ENTRY_W-1:0] v);
    reply_t r;
    int     pick;
    int     low_age;
    bit     found;
    r = '0;
    r.blk = b;
    tally[int'(f)]++;
    // every 10-bit block id addresses a real block at the default size
    case (f)
      FUNC_ALLOC: begin
        pick = GUARDED;
        low_age = int'(AGE_IMMORTAL);
        found = 1'b0;
        for (int i = GUARDED; i < BLOCKS && !found; i++) begin
          if (tbl[i] == '0) begin
            found = 1'b1;
            pick = i;
          end else if (int'(tbl[i][AGE_W-1:0]) < low_age) begin
            pick = i;
            low_age = int'(tbl[i][AGE_W-1:0]);
          end
        end
        r.blk = BLK_W'(pick);
        r.prior = tbl[pick];
        if (found) begin
          if (used < USED_CAP) used++;
        end else begin
          // no free block: evict the oldest, ageing everything first unless it is at age 0
          if (low_age > 0) age_table();
          r.evicted = 1'b1;
          evictions++;
        end
        tbl[pick] = {ft, AGE_BIRTH};
        // free space in sixteenths against the anchor age held in block 0
        if (AVAIL_SLOTS - (used * AVAIL_SLOTS) / BLOCKS < int'(tbl[0][AGE_W-1:0])) begin
          age_table();
        end
      end
      FUNC_FREE: begin
        r.prior = tbl[b];
        if (int'(b) >= GUARDED) begin
          tbl[b] = '0;
          if (used > 0) used--;
        end else begin
          r.refused = 1'b1;
          refusals++;
        end
      end
      FUNC_ROOT: begin
        r.prior = tbl[b];
        tbl[b][AGE_W-1:0] = AGE_IMMORTAL;
      end
      default: begin
        r.prior = tbl[b];
        tbl[b] = v;
      end
    endcase
    r.used = USED_W'(used);
    if (used > peak_used) peak_used = used;
    due.push_back(r);
  endfunction

  function void compare_field(string name, logic [USED_W-1:0] want, logic [USED_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_reply(logic [BLK_W-1:0] blk, logic refused, logic evicted,
                            logic [ENTRY_W-1:0] prior, logic [USED_W-1:0] used_now);
    reply_t e;
    if (due.size() == 0) begin
      $display("%0t: reply for block %0d with nothing outstanding", $time, blk);
      errors++;
      return;
    end
    e = due.pop_front();
    checked++;
    compare_field("result_block", USED_W'(e.blk), USED_W'(blk));
    compare_field("status", USED_W'(e.refused), USED_W'(refused));
    compare_field("reallocated", USED_W'(e.evicted), USED_W'(evicted));
    compare_field("previous_entry", USED_W'(e.prior), USED_W'(prior));
    compare_field("used_count", e.used, used_now);
  endfunction
endclass

module tb;

  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 3200;   // a bit above the worst allocate latency
  localparam int WATCHDOG_LIMIT = 20000;  // worst allocate plus the long hold, many times over

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic [FUNC_W-1:0]  in_func        = FUNC_ALLOC;
  logic [TYPE_W-1:0]  in_ftype       = '0;
  logic [BLK_W-1:0]   in_blk_id      = '0;
  logic [ENTRY_W-1:0] in_entry_value = '0;
  logic               out_ready      = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [BLK_W-1:0]   out_result_block;
  logic               out_status;
  logic               out_reallocated;
  logic [ENTRY_W-1:0] out_previous_entry;
  logic [USED_W-1:0]  out_used_count;

  block_table_tracker tracker = new;

  // Set by the stimulus to ask the result side for one long stall.
  bit hold_ask = 1'b0;
  // Transfers left in the current sender burst.
  int burst_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  flash_block_allocator_with_aging #(
    .BLOCK_COUNT     (BLOCKS),
    .PROTECTED_COUNT (GUARDED)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_ftype           (in_ftype),
    .in_blk_id          (in_blk_id),
    .in_entry_value     (in_entry_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_block   (out_result_block),
    .out_status         (out_status),
    .out_reallocated    (out_reallocated),
    .out_previous_entry (out_previous_entry),
    .out_used_count     (out_used_count)
  );

  // Offer one request, hold it until the transfer, then predict its reply.
  // Called at a rising edge; returns at the edge of the transfer or after a gap.
  task automatic send(func_t f, logic [TYPE_W-1:0] ft, logic [BLK_W-1:0] b,
                      logic [ENTRY_W-1:0] v);
    in_valid       <= 1'b1;
    in_func        <= f;
    in_ftype       <= ft;
    in_blk_id      <= b;
    in_entry_value <= v;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.take_request(f, ft, b, v);
    // Keep valid up inside a burst; drop it for a random gap between bursts.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(0, 15);
    end
  endtask

  // Stop offering and wait until every predicted reply has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.due.size() != 0);
  endtask

  // One random request. Blocks fall mostly in 0..span; a quarter of the loads
  // retarget block 0 so the ageing anchor keeps moving.
  task automatic random_request(int alloc_w, int free_w, int root_w, int span);
    int                 r;
    func_t              f;
    logic [BLK_W-1:0]   b;
    logic [ENTRY_W-1:0] v;
    r = $urandom_range(0, 99);
    if (span >= BLOCKS - 1 || $urandom_range(0, 7) == 0) begin
      b = BLK_W'($urandom_range(0, BLOCKS - 1));
    end else begin
      b = BLK_W'($urandom_range(0, span));
    end
    v = ENTRY_W'($urandom_range(0, 255));
    if (r < alloc_w) begin
      f = FUNC_ALLOC;
    end else if (r < alloc_w + free_w) begin
      f = FUNC_FREE;
    end else if (r < alloc_w + free_w + root_w) begin
      f = FUNC_ROOT;
    end else begin
      f = FUNC_LOAD;
      if ($urandom_range(0, 3) == 0) b = '0;
    end
    send(f, TYPE_W'($urandom_range(0, 15)), b, v);
  endtask

  // Result side: check each transfer and pace out_ready in modes of random length,
  // with one long hold-off on request.
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_left;
    int tick;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        tracker.check_reply(out_result_block, out_status, out_reallocated,
                            out_previous_entry, out_used_count);
      end
      if (hold_ask) begin
        hold_ask = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (tick % 5) < 3;
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // End the run if no transfer happens on either channel for too long.
  initial begin : stall_guard
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [ENTRY_W-1:0] v;
    int                 span;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: saturating free on an empty table, protected refusals, roots on
    // protected and free blocks, hole reuse, and the extremes of every field.
    send(FUNC_FREE,  4'h0, 10'd5,    8'h00);
    send(FUNC_FREE,  4'h0, 10'd0,    8'h00);
    send(FUNC_FREE,  4'hF, 10'd1,    8'hFF);
    send(FUNC_ROOT,  4'h0, 10'd0,    8'h00);
    send(FUNC_LOAD,  4'h0, 10'd0,    8'h00);
    send(FUNC_ALLOC, 4'h0, 10'd0,    8'h00);
    send(FUNC_ALLOC, 4'hF, 10'd1023, 8'hFF);
    send(FUNC_ALLOC, 4'hA, 10'd0,    8'h00);
    send(FUNC_FREE,  4'h0, 10'd3,    8'h00);
    send(FUNC_ALLOC, 4'h5, 10'd0,    8'h00);
    send(FUNC_ROOT,  4'h0, 10'd4,    8'h00);
    send(FUNC_LOAD,  4'h0, 10'd1023, 8'hFF);
    send(FUNC_FREE,  4'h0, 10'd1023, 8'h00);
    send(FUNC_ROOT,  4'h0, 10'd1023, 8'h00);
    send(FUNC_LOAD,  4'h0, 10'd512,  8'h30);
    send(FUNC_LOAD,  4'h0, 10'd1,    8'hAA);
    send(FUNC_ROOT,  4'h0, 10'd1,    8'h00);
    send(FUNC_LOAD,  4'h0, 10'd0,    8'h0F);
    send(FUNC_ALLOC, 4'h9, 10'd0,    8'h00);
    send(FUNC_LOAD,  4'h0, 10'd0,    8'h00);
    send(FUNC_LOAD,  4'h0, 10'd682,  8'h55);
    send(FUNC_LOAD,  4'h0, 10'd341,  8'hAA);
    drain();

    // Grow: mostly allocations so the used count climbs far enough for the
    // anchor-driven ageing. Open with a long result stall to back up the input.
    hold_ask = 1'b1;
    repeat (170) begin
      span = (tracker.used + 40 < BLOCKS - 1) ? tracker.used + 40 : BLOCKS - 1;
      random_request(80, 5, 5, span);
    end
    drain();

    // Scatter mortal ages over the unprotected blocks, then run mixed traffic.
    repeat (30) begin
      v = {4'($urandom_range(0, 15)), 4'($urandom_range(1, 14))};
      send(FUNC_LOAD, 4'h0, BLK_W'($urandom_range(GUARDED, BLOCKS - 1)), v);
    end
    repeat (70) random_request(65, 12, 8, BLOCKS - 1);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d allocations (%0d evicting), %0d frees (%0d refused),",
             tracker.tally[FUNC_ALLOC], tracker.evictions, tracker.tally[FUNC_FREE],
             tracker.refusals);
    $display("%0d roots, %0d loads; %0d replies checked, used count peaked at %0d.",
             tracker.tally[FUNC_ROOT], tracker.tally[FUNC_LOAD], tracker.checked,
             tracker.peak_used);
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
